// ===== rtl/msnc_pkg.sv =====
// Package for the markup-stripping text normalizer with CRC-32.
// Holds the channel payload types, the normalizer state and plan types,
// the character constants and the CRC-32 byte fold. Depends on nothing.
`default_nettype none

package msnc_pkg;

   localparam logic [7:0]  CH_LT     = 8'h3C;  // '<'
   localparam logic [7:0]  CH_GT     = 8'h3E;  // '>'
   localparam logic [7:0]  CH_AT     = 8'h40;  // '@'
   localparam logic [7:0]  CH_HASH   = 8'h23;  // '#'
   localparam logic [7:0]  CH_DEL    = 8'h7F;
   localparam logic [7:0]  CH_QUOTE  = 8'h22;
   localparam logic [7:0]  CH_SPACE  = 8'h20;
   localparam logic [7:0]  CH_DOT    = 8'h2E;  // '.'

   localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_summary;
      logic [31:0] crc_value;
      logic        text_changed;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic        inside_markup;
      logic        previous_was_space;
      logic [31:0] running_crc;
      logic [31:0] previous_text_crc;
   } state_type;

   // What one input transaction produces, and the state it leaves behind.
   typedef struct packed {
      logic [1:0]  emit_count;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic        has_summary;
      logic [31:0] summary_crc;
      logic        text_changed;
      state_type   next_state;
   } plan_type;

   // Reflected CRC-32 update with one byte, LSB first.
   function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/msnc_norm.sv =====
// Classifies one raw byte against the normalizer state and works out the
// bytes to emit, the CRC after them, the summary and the next state.
// Depends on msnc_pkg.
`default_nettype none

module msnc_norm (
   input  var msnc_pkg::req_type   item,
   input  var msnc_pkg::state_type cur,
   output var msnc_pkg::plan_type  plan
);

   logic [7:0]  ch;
   logic [1:0]  emit_count;
   logic [7:0]  byte0;
   logic [7:0]  byte1;
   logic        next_inside;
   logic        next_space;
   logic [31:0] crc_one;
   logic [31:0] crc_two;
   logic [31:0] final_crc;

   assign ch = item.in_byte;

   always_comb begin
      emit_count  = 2'd0;
      byte0       = 8'h00;
      byte1       = 8'h00;
      next_inside = cur.inside_markup;
      next_space  = cur.previous_was_space;

      if (ch == msnc_pkg::CH_GT) begin
         next_inside = 1'b0;
      end else if (ch == msnc_pkg::CH_LT) begin
         next_inside = 1'b1;
      end else if (cur.inside_markup) begin
         emit_count = 2'd0;
      end else if (ch == msnc_pkg::CH_AT || ch == msnc_pkg::CH_HASH ||
                   ch == msnc_pkg::CH_DEL) begin
         emit_count = 2'd0;
      end else if (ch == msnc_pkg::CH_QUOTE) begin
         // A quote leaves the space-run flag alone.
         emit_count = 2'd2;
         byte0      = msnc_pkg::CH_DOT;
         byte1      = msnc_pkg::CH_QUOTE;
      end else if (ch <= msnc_pkg::CH_SPACE) begin
         if (!cur.previous_was_space) begin
            emit_count = 2'd1;
            byte0      = msnc_pkg::CH_SPACE;
            next_space = 1'b1;
         end
      end else begin
         emit_count = 2'd1;
         byte0      = ch;
         next_space = 1'b0;
      end
   end

   assign crc_one   = (emit_count != 2'd0) ?
                      msnc_pkg::crc_fold(cur.running_crc, byte0) : cur.running_crc;
   assign crc_two   = (emit_count == 2'd2) ?
                      msnc_pkg::crc_fold(crc_one, byte1) : crc_one;
   assign final_crc = ~crc_two;

   always_comb begin
      plan                               = '0;
      plan.emit_count                    = emit_count;
      plan.byte0                         = byte0;
      plan.byte1                         = byte1;
      plan.has_summary                   = item.end_of_text;
      plan.summary_crc                   = final_crc;
      plan.text_changed                  = (final_crc != cur.previous_text_crc);
      plan.next_state                    = cur;
      plan.next_state.inside_markup      = next_inside;
      plan.next_state.previous_was_space = next_space;
      plan.next_state.running_crc        = crc_two;

      if (item.end_of_text) begin
         plan.next_state.previous_text_crc  = final_crc;
         plan.next_state.running_crc        = msnc_pkg::CRC_INIT;
         plan.next_state.inside_markup      = 1'b0;
         plan.next_state.previous_was_space = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/markup_strip_text_normalizer_crc.sv =====
// Top level of the markup-stripping text normalizer with CRC-32: input
// register, result sequencing and output register. Depends on msnc_pkg
// and msnc_norm.
//
//   Channel | Ports                           | Direction | Payload
//   req     | req_valid, req_ready, req_data  | in        | msnc_pkg::req_type
//   rsp     | rsp_valid, rsp_ready, rsp_data  | out       | msnc_pkg::rsp_type
//
// A transaction sits in the input register until all its results (if any,
// one to three) are loaded into the result register. One result drains per
// cycle unless rsp stalls, so the result count sets the rate.
// A new transaction is taken in the cycle the held one finishes.
// Reset clears the text state (CRC to all ones) and empties both stages.
// A stall on rsp holds the result register and, through it, the input stage.
`default_nettype none

module markup_strip_text_normalizer_crc (
   input  var logic              clock,
   input  var logic              reset,
   input  var logic              req_valid,
   output var logic              req_ready,
   input  var msnc_pkg::req_type req_data,
   output var logic              rsp_valid,
   input  var logic              rsp_ready,
   output var msnc_pkg::rsp_type rsp_data
);

   logic                item_valid_ff, item_valid_in;
   msnc_pkg::req_type   item_ff, item_in;
   logic [1:0]          idx_ff, idx_in;
   msnc_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   msnc_pkg::rsp_type   rsp_ff, rsp_in;

   msnc_pkg::plan_type  plan;
   msnc_pkg::rsp_type   cur_result;
   logic [1:0]          result_count;
   logic                out_load;
   logic                last_result;
   logic                item_done;
   logic                req_accept;

   msnc_norm u_norm (
      .item (item_ff),
      .cur  (state_ff),
      .plan (plan)
   );

   assign result_count = plan.emit_count + {1'b0, plan.has_summary};
   assign last_result  = (idx_ff == result_count - 2'd1);
   assign out_load     = item_valid_ff && (result_count != 2'd0) &&
                         (!rsp_valid_ff || rsp_ready);
   assign item_done    = item_valid_ff &&
                         ((result_count == 2'd0) || (out_load && last_result));
   assign req_ready    = !item_valid_ff || item_done;
   assign req_accept   = req_valid && req_ready;

   // Bytes come first, then the summary.
   always_comb begin
      cur_result             = '0;
      cur_result.last_of_run = last_result;
      if (idx_ff < plan.emit_count) begin
         cur_result.out_byte = (idx_ff == 2'd0) ? plan.byte0 : plan.byte1;
      end else begin
         cur_result.is_summary   = 1'b1;
         cur_result.crc_value    = plan.summary_crc;
         cur_result.text_changed = plan.text_changed;
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      state_in      = state_ff;
      if (item_done) begin
         item_valid_in = 1'b0;
         idx_in        = 2'd0;
         state_in      = plan.next_state;
      end else if (out_load) begin
         idx_in = idx_ff + 2'd1;
      end
      if (req_accept) begin
         item_valid_in = 1'b1;
         item_in       = req_data;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = cur_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff              <= 1'b0;
         idx_ff                     <= 2'd0;
         state_ff.inside_markup      <= 1'b0;
         state_ff.previous_was_space <= 1'b0;
         state_ff.running_crc        <= msnc_pkg::CRC_INIT;
         state_ff.previous_text_crc  <= '0;
         rsp_valid_ff               <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         idx_ff        <= idx_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A summary always closes the run of results from its transaction.
   a_summary_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_summary |-> rsp_ff.last_of_run)
      else $error("summary result without last_of_run");

   a_byte_fields_clear : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.is_summary |->
         (rsp_ff.crc_value == 32'd0) && !rsp_ff.text_changed)
      else $error("byte result carries summary fields");

   a_idx_in_range : assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd3)
      else $error("result index out of range");

   a_idx_idle_zero : assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> idx_ff == 2'd0)
      else $error("result index not cleared with empty input stage");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !item_valid_ff)
      else $error("stages not empty after reset");

endmodule

`default_nettype wire
